// ===== hdl/mte_pkg.sv =====
// Shared types and constants of the multi-tap echo mixer.
`default_nettype none
package mte_pkg;
   localparam int unsigned Q16_ONE = 65536;
   localparam int MAX_TAPS = 8;
   localparam int HISTORY_DEPTH = 16384;

   typedef enum logic [2:0] {
      CSR_TAP_COUNT     = 3'd0,
      CSR_DELAY_INTERVAL = 3'd1,
      CSR_DELAY_RATIO   = 3'd2,
      CSR_DECAY_MODE    = 3'd3,
      CSR_DECAY_COMMON  = 3'd4,
      CSR_WIDE_SAMPLES  = 3'd5
   } csr_index_type;

   // item handed from front to back
   typedef struct packed {
      logic [15:0] sample;
      logic        is_original;
      logic        last;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WRITE,
      BK_READ,
      BK_MUL,
      BK_ADD,
      BK_EMIT,
      BK_CLEAR
   } back_state_type;

   typedef enum logic [1:0] {
      TB_IDLE,
      TB_MUL,
      TB_STORE
   } table_state_type;
endpackage
`default_nettype wire

// ===== hdl/mte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mte_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/mte_tables.sv =====
// Tap delay and gain table builder, rerun after each register write.
`default_nettype none
module mte_tables (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          start,
   input  wire logic [14:0]                                   delay_interval,
   input  wire logic [16:0]                                   delay_ratio,
   input  wire logic                                          decay_mode,
   input  wire logic [16:0]                                   decay_common,
   input  wire logic                                          wide_samples,
   output logic                                               busy,
   input  wire logic [$clog2(mte_pkg::MAX_TAPS)-1:0]          tap_sel,
   output logic      [$clog2(mte_pkg::HISTORY_DEPTH):0]       tap_delay,
   output logic signed [19:0]                                 tap_gain
);
   localparam int MAX_TAPS = mte_pkg::MAX_TAPS;
   localparam int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH;
   localparam int TW = $clog2(MAX_TAPS);
   localparam int DW = $clog2(HISTORY_DEPTH) + 1;
   localparam logic [TW:0] TAPS = (TW+1)'(MAX_TAPS);

   mte_pkg::table_state_type state_ff, state_in;
   logic [TW:0]  k_ff, k_in;
   logic [16:0]  pw_ff, pw_in, gp_ff, gp_in;
   logic [DW-1:0] cum_ff, cum_in;
   logic [32:0]  step_prod_ff;
   logic [33:0]  gp_prod_ff;
   logic [DW-1:0] delay_ff [MAX_TAPS];
   logic signed [19:0] gain_ff [MAX_TAPS];
   logic [16:0]  ratio, common;
   logic [31:0]  step;
   logic [32:0]  cum_sum;
   logic signed [23:0] lin_gain;

   assign ratio  = (delay_ratio > 17'(mte_pkg::Q16_ONE)) ? 17'(mte_pkg::Q16_ONE) : delay_ratio;
   assign common = (decay_common > 17'(mte_pkg::Q16_ONE)) ? 17'(mte_pkg::Q16_ONE)
                                                          : decay_common;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mte_pkg::TB_IDLE:  state_in = mte_pkg::TB_IDLE;
         mte_pkg::TB_MUL:   state_in = mte_pkg::TB_STORE;
         mte_pkg::TB_STORE: if (k_ff == TAPS - 1'b1) state_in = mte_pkg::TB_IDLE;
                            else state_in = mte_pkg::TB_MUL;
         default:           state_in = mte_pkg::TB_IDLE;
      endcase
      // a write during a build restarts it with the latest registers
      if (start) state_in = mte_pkg::TB_MUL;
   end

   assign busy = (state_ff != mte_pkg::TB_IDLE);

   // step from registered product of interval and power
   always_comb begin
      if (wide_samples) begin
         step = 32'(((step_prod_ff[32:15]) + 18'd1) >> 1);
      end else begin
         step = 32'(step_prod_ff[32:16]);
      end
      cum_sum  = 33'(cum_ff) + 33'(step);
      lin_gain = 24'sd65536 - 24'($signed({1'b0, common}) * $signed({1'b0, k_ff + 1'b1}));
   end

   always_comb begin
      k_in   = k_ff;
      pw_in  = pw_ff;
      gp_in  = gp_ff;
      cum_in = cum_ff;
      if (start) begin
         k_in   = '0;
         pw_in  = 17'(mte_pkg::Q16_ONE);
         gp_in  = 17'(mte_pkg::Q16_ONE);
         cum_in = '0;
      end else if (state_ff == mte_pkg::TB_STORE) begin
         k_in   = k_ff + 1'b1;
         pw_in  = 17'((34'(pw_ff) * 34'(ratio)) >> 16);
         gp_in  = gp_prod_ff[32:16];
         cum_in = (cum_sum > 33'(HISTORY_DEPTH)) ? DW'(HISTORY_DEPTH) : cum_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mte_pkg::TB_MUL;
         k_ff     <= '0;
         pw_ff    <= 17'(mte_pkg::Q16_ONE);
         gp_ff    <= 17'(mte_pkg::Q16_ONE);
         cum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pw_ff    <= pw_in;
         gp_ff    <= gp_in;
         cum_ff   <= cum_in;
      end
   end

   always_ff @(posedge clock) begin
      step_prod_ff <= 33'(pw_ff) * 33'(delay_interval);
      gp_prod_ff   <= 34'(gp_ff) * 34'(common);
      if (state_ff == mte_pkg::TB_STORE) begin
         delay_ff[k_ff[TW-1:0]] <= (cum_sum > 33'(HISTORY_DEPTH)) ? DW'(HISTORY_DEPTH)
                                                                 : cum_sum[DW-1:0];
         gain_ff[k_ff[TW-1:0]]  <= decay_mode ? $signed({3'b0, gp_prod_ff[32:16]})
                                              : lin_gain[19:0];
      end
   end

   assign tap_delay = delay_ff[tap_sel];
   assign tap_gain  = gain_ff[tap_sel];
endmodule
`default_nettype wire

// ===== hdl/mte_front.sv =====
// Front end: takes items and holds them in a short queue for the back end.
`default_nettype none
module mte_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [15:0]      sample,
   input  wire logic             is_original,
   input  wire logic             last,
   output logic                  item_valid,
   output mte_pkg::item_type     item,
   input  wire logic             item_take
);
   mte_pkg::item_type q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= '{sample: sample, is_original: is_original, last: last};
      end
   end
endmodule
`default_nettype wire

// ===== hdl/mte_back.sv =====
// Back end: history store, per-tap multiply-add, saturation and result register.
`default_nettype none
module mte_back (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    item_valid,
   input  wire mte_pkg::item_type                       item,
   output logic                                         item_take,
   input  wire logic                                    tables_busy,
   input  wire logic [3:0]                              tap_count,
   input  wire logic                                    decay_mode,
   input  wire logic                                    wide_samples,
   output logic      [$clog2(mte_pkg::MAX_TAPS)-1:0]    tap_sel,
   input  wire logic [$clog2(mte_pkg::HISTORY_DEPTH):0] tap_delay,
   input  wire logic signed [19:0]                      tap_gain,
   output logic                                         empty,
   input  wire logic                                    pop,
   output logic      [15:0]                             sample_out,
   output logic                                         last_out
);
   localparam int MAX_TAPS = mte_pkg::MAX_TAPS;
   localparam int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH;
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int TW = $clog2(MAX_TAPS);
   localparam logic [4:0] TAPS = 5'(MAX_TAPS);

   mte_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    ntap;
   mte_pkg::item_type cur_ff, cur_in;
   logic signed [17:0] acc_ff, acc_in;
   logic signed [36:0] prod_ff;
   logic          skip_ff, skip_in;
   logic          out_full_ff;
   logic [15:0]   out_sample_ff;
   logic          out_last_ff;
   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [16:0]   ram_wd, ram_rd;
   logic signed [16:0] x;
   logic signed [36:0] mag;
   logic signed [20:0] q;
   logic signed [21:0] sum;
   logic signed [17:0] hi, lo, base;

   assign ntap    = (tap_count > 4'(MAX_TAPS)) ? TAPS : 5'(tap_count);
   assign tap_sel = k_ff[TW-1:0];
   assign hi = wide_samples ? 18'sd32767 : 18'sd255;
   assign lo = wide_samples ? -18'sd32768 : 18'sd0;

   mte_ram #(.WIDTH(17), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   always_comb begin
      ram_we = (state_ff == mte_pkg::BK_WRITE) || (state_ff == mte_pkg::BK_CLEAR);
      ram_wa = (state_ff == mte_pkg::BK_CLEAR) ? clr_ff : wptr_ff;
      ram_wd = (state_ff == mte_pkg::BK_CLEAR) ? 17'd0 : {cur_ff.is_original, cur_ff.sample};
      ram_ra = wptr_ff - tap_delay[AW-1:0];
   end

   always_comb begin
      if (wide_samples) base = cur_ff.is_original ? 18'($signed(cur_ff.sample)) : 18'sd0;
      else base = cur_ff.is_original ? $signed({10'b0, cur_ff.sample[7:0]}) : 18'sd128;
      if (wide_samples) x = 17'($signed(ram_rd[15:0]));
      else x = $signed({9'b0, ram_rd[7:0]}) - (decay_mode ? 17'sd128 : 17'sd127);
      mag = prod_ff[36] ? -prod_ff : prod_ff;
      q   = prod_ff[36] ? -21'(mag >>> 16) : 21'(mag >>> 16);
      sum = 22'(acc_ff) + 22'(q);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mte_pkg::BK_IDLE:
            if (item_valid && !tables_busy) state_in = mte_pkg::BK_WRITE;
         mte_pkg::BK_WRITE:
            state_in = (ntap == 5'd0) ? mte_pkg::BK_EMIT : mte_pkg::BK_READ;
         mte_pkg::BK_READ:  state_in = mte_pkg::BK_MUL;
         mte_pkg::BK_MUL:   state_in = mte_pkg::BK_ADD;
         mte_pkg::BK_ADD:
            state_in = (k_ff + 5'd1 >= ntap) ? mte_pkg::BK_EMIT : mte_pkg::BK_READ;
         // hold here until the result register is free
         mte_pkg::BK_EMIT:
            if (!out_full_ff) state_in = cur_ff.last ? mte_pkg::BK_CLEAR : mte_pkg::BK_IDLE;
         mte_pkg::BK_CLEAR:
            if (clr_ff == '1) state_in = mte_pkg::BK_IDLE;
         default: state_in = mte_pkg::BK_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      item_take = (state_ff == mte_pkg::BK_IDLE) && item_valid && !tables_busy;
      cur_in  = cur_ff;
      acc_in  = acc_ff;
      k_in    = k_ff;
      wptr_in = wptr_ff;
      clr_in  = clr_ff;
      skip_in = skip_ff;
      unique case (state_ff)
         mte_pkg::BK_IDLE: begin
            if (item_take) cur_in = item;
            k_in   = '0;
            clr_in = '0;
         end
         mte_pkg::BK_WRITE: acc_in = base;
         mte_pkg::BK_READ:
            skip_in = (tap_delay >= (AW+1)'(HISTORY_DEPTH));
         mte_pkg::BK_MUL: if (!ram_rd[16]) skip_in = 1'b1;
         mte_pkg::BK_ADD: begin
            if (!skip_ff) begin
               if (sum > 22'(hi)) acc_in = hi;
               else if (sum < 22'(lo)) acc_in = lo;
               else acc_in = sum[17:0];
            end
            k_in = k_ff + 5'd1;
         end
         mte_pkg::BK_EMIT: if (!out_full_ff) wptr_in = cur_ff.last ? '0 : wptr_ff + 1'b1;
         mte_pkg::BK_CLEAR: clr_in = clr_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mte_pkg::BK_CLEAR;
         wptr_ff     <= '0;
         clr_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         clr_ff   <= clr_in;
         if (state_ff == mte_pkg::BK_EMIT && !out_full_ff) out_full_ff <= 1'b1;
         else if (pop) out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      skip_ff <= skip_in;
      prod_ff <= 37'(x) * 37'(tap_gain);
      if (state_ff == mte_pkg::BK_EMIT && !out_full_ff) begin
         out_sample_ff <= acc_ff[15:0];
         out_last_ff   <= cur_ff.last;
      end
   end

   assign empty      = !out_full_ff;
   assign sample_out = out_sample_ff;
   assign last_out   = out_last_ff;
endmodule
`default_nettype wire

// ===== hdl/multi_tap_echo_mixer.sv =====
// Top level of the multi-tap echo mixer.
// Each item is written to history, then gets one history read, multiply and saturating
// add per tap in turn, set by the single history RAM read port; the input queue holds
// two items while the back end works, and a finished item waits in the back end's last
// step while the previous result is still unpopped. After reset and after every item
// with last_in set, the history RAM is cleared entry by entry, and after each register
// write the tap tables are rebuilt; no new item is started meanwhile, though an item
// already under way runs on during a rebuild.
`default_nettype none
module multi_tap_echo_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [15:0] req_sample_in,
   input  wire logic        req_is_original,
   input  wire logic        req_last_in,
   output logic             empty,
   input  wire logic        pop,
   output logic      [15:0] rsp_sample_out,
   output logic             rsp_last_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   localparam int TW = $clog2(mte_pkg::MAX_TAPS);
   localparam int AW = $clog2(mte_pkg::HISTORY_DEPTH);

   logic [3:0]  tap_count_ff;
   logic [14:0] delay_interval_ff;
   logic [16:0] delay_ratio_ff;
   logic        decay_mode_ff;
   logic [16:0] decay_common_ff;
   logic        wide_samples_ff;
   logic        csr_wr, csr_hit;
   logic        item_valid, item_take, tables_busy;
   mte_pkg::item_type item;
   logic [TW-1:0] tap_sel;
   logic [AW:0]   tap_delay;
   logic signed [19:0] tap_gain;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      unique case (csr_index)
         mte_pkg::CSR_TAP_COUNT, mte_pkg::CSR_DELAY_INTERVAL, mte_pkg::CSR_DELAY_RATIO,
         mte_pkg::CSR_DECAY_MODE, mte_pkg::CSR_DECAY_COMMON,
         mte_pkg::CSR_WIDE_SAMPLES: csr_hit = 1'b1;
         default: csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff      <= '0;
         delay_interval_ff <= '0;
         delay_ratio_ff    <= '0;
         decay_mode_ff     <= 1'b0;
         decay_common_ff   <= '0;
         wide_samples_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_index)
            mte_pkg::CSR_TAP_COUNT:      tap_count_ff      <= csr_data[3:0];
            mte_pkg::CSR_DELAY_INTERVAL: delay_interval_ff <= csr_data[14:0];
            mte_pkg::CSR_DELAY_RATIO:    delay_ratio_ff    <= csr_data;
            mte_pkg::CSR_DECAY_MODE:     decay_mode_ff     <= csr_data[0];
            mte_pkg::CSR_DECAY_COMMON:   decay_common_ff   <= csr_data;
            mte_pkg::CSR_WIDE_SAMPLES:   wide_samples_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic rebuild_ff;
   always_ff @(posedge clock) begin
      if (reset) rebuild_ff <= 1'b0;
      else rebuild_ff <= csr_wr && csr_hit;
   end

   mte_tables u_tables (
      .clock(clock), .reset(reset), .start(rebuild_ff),
      .delay_interval(delay_interval_ff), .delay_ratio(delay_ratio_ff),
      .decay_mode(decay_mode_ff), .decay_common(decay_common_ff),
      .wide_samples(wide_samples_ff), .busy(tables_busy),
      .tap_sel(tap_sel), .tap_delay(tap_delay), .tap_gain(tap_gain)
   );

   mte_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .sample(req_sample_in), .is_original(req_is_original), .last(req_last_in),
      .item_valid(item_valid), .item(item), .item_take(item_take)
   );

   mte_back u_back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item(item),
      .item_take(item_take), .tables_busy(tables_busy || rebuild_ff),
      .tap_count(tap_count_ff), .decay_mode(decay_mode_ff),
      .wide_samples(wide_samples_ff), .tap_sel(tap_sel), .tap_delay(tap_delay),
      .tap_gain(tap_gain), .empty(empty), .pop(pop),
      .sample_out(rsp_sample_out), .last_out(rsp_last_out)
   );
endmodule
`default_nettype wire

// ===== hdl/mte_checker.sv =====
// Port-level checker for the multi-tap echo mixer, bound to the top level.
`default_nettype none
module mte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [15:0] rsp_sample_out,
   input wire logic        rsp_last_out
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_sample_out) && $stable(rsp_last_out))
      else $error("result changed while waiting");
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown after reset");
   a_reset_notfull: assert property (@(posedge clock) reset |=> !full)
      else $error("queue full after reset");
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      !empty && pop |=> empty)
      else $error("result shown again after pop");
endmodule

bind multi_tap_echo_mixer mte_checker u_mte_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_sample_out(rsp_sample_out), .rsp_last_out(rsp_last_out)
);
`default_nettype wire
